// ===== design/deq_pkg.sv =====
// Shared types and constants for the double-ended queue core.
`default_nettype none
package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH_REAR  = 2'd0,
        F_PUSH_FRONT = 2'd1,
        F_POP_REAR   = 2'd2,
        F_POP_FRONT  = 2'd3
    } func_t;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_PUSH_FRONT,
        C_POP_FRONT,
        C_PUSH_REAR,
        C_LOAD,
        C_DRAIN
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [WORD_W-1:0]        value;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/deq_cell.sv =====
// One storage cell of the queue chain: a word plus a carry word for rear reads.
`default_nettype none
module deq_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  wire logic                         clk,
    input  wire deq_pkg::cell_ctrl_t          ctrl,
    input  wire logic [CNT_W-1:0]             count,
    input  wire logic [deq_pkg::WORD_W-1:0]   word_prev,
    input  wire logic [deq_pkg::WORD_W-1:0]   word_nxt,
    input  wire logic [deq_pkg::WORD_W-1:0]   carry_nxt,
    output logic      [deq_pkg::WORD_W-1:0]   word,
    output logic      [deq_pkg::WORD_W-1:0]   carry
);
    import deq_pkg::*;

    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] carry_reg, carry_next;
    logic              is_tail;

    // this cell is the first free slot behind the rear word
    assign is_tail = (count == CNT_W'(INDEX));

    always_comb
    begin
        word_next  = word_reg;
        carry_next = carry_reg;
        case (ctrl.op)
            C_PUSH_FRONT: word_next = word_prev;
            C_POP_FRONT:  word_next = word_nxt;
            C_PUSH_REAR:
            begin
                if (is_tail)
                begin
                    word_next = ctrl.value;
                end
            end
            C_LOAD:       carry_next = word_reg;
            C_DRAIN:      carry_next = carry_nxt;
            default:
            begin
                word_next  = word_reg;
                carry_next = carry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        carry_reg <= carry_next;
    end

    assign word  = word_reg;
    assign carry = carry_reg;

endmodule
`default_nettype wire

// ===== design/double_ended_queue_core.sv =====
// Top level of the double-ended queue core: cell chain plus request control.
`default_nettype none
// Double-ended queue of DEPTH signed 32-bit words held in a chain of cells,
// front word always in cell 0. Push front, pop front and push rear complete
// directly from the idle state, as does any request that ends in status empty
// or full, and a pop at the rear when one word is held. A pop at the rear with
// N > 1 words held first copies the words into the carry chain, then walks
// the rear word down to cell 0 one cell per cycle, and then registers the
// result. Every request gives one result with status, popped
// data and the new occupancy (held count, low 5 bits). A push when full is
// dropped with status full; a pop when empty returns 0 with status empty. The
// output register lets a new request in during the cycle its result is taken.
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [deq_pkg::FUNC_W-1:0]   func,
    input  wire logic signed [deq_pkg::WORD_W-1:0]   value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [deq_pkg::WORD_W-1:0]   data,
    output logic             [deq_pkg::STATUS_W-1:0] status,
    output logic             [deq_pkg::OCC_W-1:0]    occupancy
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]   data_reg, data_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    cell_ctrl_t ctrl;
    logic [WORD_W-1:0] word_w  [DEPTH];
    logic [WORD_W-1:0] carry_w [DEPTH];

    logic        accept;
    logic        is_full;
    logic        is_empty;
    logic        res_load;
    func_t       func_op;
    logic [EXT_W-1:0] count_ext;

    assign func_op  = func_t'(func);
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] prev_w, nxt_w, cnxt_w;
        if (i == 0)
        begin : g_first
            assign prev_w = ctrl.value;
        end
        else
        begin : g_mid
            assign prev_w = word_w[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign nxt_w  = '0;
            assign cnxt_w = '0;
        end
        else
        begin : g_inner
            assign nxt_w  = word_w[i+1];
            assign cnxt_w = carry_w[i+1];
        end
        deq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .word_prev (prev_w),
            .word_nxt  (nxt_w),
            .carry_nxt (cnxt_w),
            .word      (word_w[i]),
            .carry     (carry_w[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (func_op == F_POP_REAR) && !is_empty &&
                    (count_reg != CNT_W'(1)))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (remain_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // cell control and result
    always_comb
    begin
        ctrl.op     = C_HOLD;
        ctrl.value  = value;
        count_next  = count_reg;
        remain_next = remain_reg;
        res_load    = 1'b0;
        data_next   = data_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_load    = 1'b1;
                    data_next   = '0;
                    status_next = ST_DONE;
                    unique case (func_op)
                        F_PUSH_REAR, F_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op = (func_op == F_PUSH_REAR) ? C_PUSH_REAR
                                                                   : C_PUSH_FRONT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        F_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.op    = C_POP_FRONT;
                                data_next  = word_w[0];
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        F_POP_REAR:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (count_reg == CNT_W'(1))
                                begin
                                    data_next = word_w[0];
                                end
                                else
                                begin
                                    // snapshot words, then shift rear word down
                                    ctrl.op     = C_LOAD;
                                    remain_next = count_reg - CNT_W'(1);
                                    res_load    = 1'b0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if (remain_reg == '0)
                begin
                    res_load    = 1'b1;
                    data_next   = carry_w[0];
                    status_next = ST_DONE;
                end
                else
                begin
                    ctrl.op     = C_DRAIN;
                    remain_next = remain_reg - CNT_W'(1);
                end
            end
        endcase
    end

    assign count_ext = EXT_W'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        occ_next       = occ_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            occ_next       = count_ext[OCC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
        occ_reg    <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

endmodule
`default_nettype wire

// ===== bench/tb_double_ended_queue_core.sv =====
// Self-checking testbench for double_ended_queue_core with a scoreboard class.
`timescale 1ns / 1ps

module tb_double_ended_queue_core;
    import deq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;

    typedef struct {
        logic signed [WORD_W-1:0]   data;
        logic        [STATUS_W-1:0] status;
        logic        [OCC_W-1:0]    occupancy;
    } deq_result_t;

    // Mirror of the deque plus the queue of results still owed by the block.
    class deque_scoreboard;
        logic signed [WORD_W-1:0] words [DEPTH];
        int unsigned front_idx;
        int unsigned rear_idx;
        int unsigned held;
        deq_result_t owed_q [$];
        int errors;
        int n_checked;
        int n_push;
        int n_pop;
        int n_full;
        int n_empty;

        function new();
            front_idx = 0;
            rear_idx  = 0;
            held      = 0;
            errors    = 0;
            n_checked = 0;
            n_push    = 0;
            n_pop     = 0;
            n_full    = 0;
            n_empty   = 0;
        endfunction

        function void note_request(func_t f, logic signed [WORD_W-1:0] v);
            deq_result_t r;
            r.data   = '0;
            r.status = ST_DONE;
            if (f == F_PUSH_REAR || f == F_PUSH_FRONT) begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    if (f == F_PUSH_REAR) begin
                        words[rear_idx] = v;
                        rear_idx = (rear_idx + 1) % DEPTH;
                    end else begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        words[front_idx] = v;
                    end
                    held++;
                    n_push++;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    if (f == F_POP_REAR) begin
                        rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
                        r.data = words[rear_idx];
                    end else begin
                        r.data = words[front_idx];
                        front_idx = (front_idx + 1) % DEPTH;
                    end
                    held--;
                    n_pop++;
                end
            end
            r.occupancy = held[OCC_W-1:0];
            owed_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
        endtask

        task check_result(logic signed [WORD_W-1:0] d, logic [STATUS_W-1:0] s,
                          logic [OCC_W-1:0] occ);
            deq_result_t e;
            n_checked++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result data=%0d status=%0d occ=%0d",
                                 d, s, occ));
            end else begin
                e = owed_q.pop_front();
                if (d !== e.data)
                    report($sformatf("data %0d, expected %0d", d, e.data));
                if (s !== e.status)
                    report($sformatf("status %0d, expected %0d", s, e.status));
                if (occ !== e.occupancy)
                    report($sformatf("occupancy %0d, expected %0d", occ, e.occupancy));
            end
        endtask

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [FUNC_W-1:0] func;
    logic signed [WORD_W-1:0] value;
    logic out_valid;
    logic out_ready;
    logic signed [WORD_W-1:0] data;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0] occupancy;

    deque_scoreboard sb;
    bit in_burst;
    bit out_burst;
    int in_count;
    int out_count;

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .data     (data),
        .status   (status),
        .occupancy(occupancy)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = F_PUSH_REAR;
        value     = '0;
        out_ready = 1'b0;
        sb        = new();
    end

    // Idle gaps: drawn uniformly at random, with occasional back-to-back stretches.
    function int draw_gap(bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    task send_request(func_t f, logic signed [WORD_W-1:0] v);
        int gap;
        if (in_count % 64 == 0)
            in_burst = ($urandom_range(0, 3) == 0);
        in_count++;
        gap = draw_gap(in_burst);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        func     <= f;
        value    <= v;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(f, v);
    endtask

    function logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall before each result, then take it.
    initial
    begin : result_taker
        int stall;
        out_count = 0;
        @(posedge rst_n);
        forever begin
            if (out_count % 64 == 0)
                out_burst = ($urandom_range(0, 3) == 0);
            out_count++;
            stall = draw_gap(out_burst);
            if (stall > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(data, status, occupancy);
        end
    end

    initial
    begin : stimulus
        int i;
        int push_pct;
        func_t f;
        in_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pops on empty, fill to full with extremes, pushes on full, then a pop at each end.
        send_request(F_POP_REAR, 32'sh1234_5678);
        send_request(F_POP_FRONT, -32'sd7);
        send_request(F_PUSH_FRONT, 32'sh8000_0000);
        send_request(F_PUSH_REAR, 32'sh7fff_ffff);
        send_request(F_PUSH_FRONT, '0);
        send_request(F_PUSH_REAR, -32'sd1);
        for (i = 0; i < DEPTH - 4; i++)
            send_request(i[0] ? F_PUSH_FRONT : F_PUSH_REAR, $urandom);
        send_request(F_PUSH_FRONT, 32'sh5555_aaaa);
        send_request(F_PUSH_REAR, 32'shaaaa_5555);
        send_request(F_POP_REAR, '0);
        send_request(F_POP_FRONT, '0);

        // Random: phases biased toward pushing or popping so the queue swings
        // between full and empty and the indices wrap both ways.
        push_pct = 50;
        for (i = 0; i < 1000; i++) begin
            if (i % 24 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            if ($urandom_range(0, 99) < push_pct)
                f = $urandom_range(0, 1) ? F_PUSH_FRONT : F_PUSH_REAR;
            else
                f = $urandom_range(0, 1) ? F_POP_FRONT : F_POP_REAR;
            send_request(f, pick_word());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.owed() != 0) @(posedge clk);
        repeat (64) @(posedge clk);

        $display("covered %0d results: %0d pushes, %0d pops, %0d dropped when full,",
                 sb.n_checked, sb.n_push, sb.n_pop, sb.n_full);
        $display("%0d pops on an empty queue, %0d mismatches", sb.n_empty, sb.errors);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("[double_ended_queue_core] OK");
        else
            $display("[double_ended_queue_core] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("timeout waiting for the block");
        $display("[double_ended_queue_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/deq_pkg.sv
design/deq_cell.sv
design/double_ended_queue_core.sv
bench/tb_double_ended_queue_core.sv
